[rtl/mwf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Median window filter package
// Sizes, command codes and the command type that passes from the front
// end through the queue to the median engine.
// ---------------------------------------------------------------------------
package mwf_pkg;

   localparam int WINDOW   = 30;
   localparam int SAMPLE_W = 10;
   localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   // Lower and upper middle ranks; equal for an odd window
   localparam logic [IDX_W-1:0] MID_LO   = IDX_W'((WINDOW - 1) / 2);
   localparam logic [IDX_W-1:0] MID_HI   = IDX_W'(WINDOW / 2);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

   typedef enum logic {
      ACT_PUSH   = 1'b0,
      ACT_REPORT = 1'b1
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [SAMPLE_W-1:0] sample;
   } cmd_type;

endpackage : mwf_pkg
`default_nettype wire

[rtl/mwf_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one push or report item.
// ---------------------------------------------------------------------------
interface mwf_req_if;
   import mwf_pkg::*;

   logic                valid;
   logic                ready;
   logic                action;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output action, output sample, input ready);
   modport sink   (input valid, input action, input sample, output ready);

endinterface : mwf_req_if
`default_nettype wire

[rtl/mwf_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one median result item.
// ---------------------------------------------------------------------------
interface mwf_rsp_if;
   import mwf_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] median_value;

   modport source (output valid, output median_value, input ready);
   modport sink   (input valid, input median_value, output ready);

endinterface : mwf_rsp_if
`default_nettype wire

[rtl/mwf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Median window filter front end
// Takes request items into a holding register and turns them into
// commands for the queue.
// ---------------------------------------------------------------------------
module mwf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   mwf_req_if.sink               req_if,
   output mwf_pkg::cmd_type      cmd_out,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready
);
   import mwf_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    req_accept;

   // Take a new item when the holding register is empty or drains now
   assign req_if.ready = !hold_valid_ff || cmd_ready;
   assign req_accept   = req_if.valid && req_if.ready;

   // Classify the item; a report carries no sample
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (req_accept) begin
         hold_valid_in      = 1'b1;
         hold_cmd_in.action = action_type'(req_if.action);
         hold_cmd_in.sample = (action_type'(req_if.action) == ACT_PUSH) ?
                              req_if.sample : '0;
      end else if (cmd_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

   assign cmd_out   = hold_cmd_ff;
   assign cmd_valid = hold_valid_ff;

endmodule : mwf_front
`default_nettype wire

[rtl/mwf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Median window filter command queue
// Two-entry queue that lets the front end run on while the engine works.
// ---------------------------------------------------------------------------
module mwf_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mwf_pkg::cmd_type wr_cmd,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   output mwf_pkg::cmd_type      rd_cmd,
   output logic                  rd_valid,
   input  wire logic             rd_ready
);
   import mwf_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_wr, do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming item
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule : mwf_queue
`default_nettype wire

[rtl/mwf_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Median window filter engine
// Holds the sample ring, writes pushes and finds the median by ranking
// every entry against all others, one compare per cycle.
// ---------------------------------------------------------------------------
module mwf_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mwf_pkg::cmd_type cmd_in,
   input  wire logic             cmd_valid,
   output logic                  cmd_ready,
   mwf_rsp_if.source             rsp_if
);
   import mwf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CAND,
      ST_SCAN,
      ST_FINISH,
      ST_OUT
   } state_type;

   // Ring storage; an entry never written reads as zero
   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0]   ring_valid_ff, ring_valid_in;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_hit_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic [SAMPLE_W-1:0] rd_eff;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    wr_pos_ff, wr_pos_in;
   logic [IDX_W-1:0]    cand_idx_ff, cand_idx_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    rank_ff, rank_in;
   logic [SAMPLE_W-1:0] cand_ff, cand_in;
   logic [SAMPLE_W-1:0] lo_ff, lo_in;
   logic [SAMPLE_W-1:0] hi_ff, hi_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic                mem_we;
   logic                below;
   logic [IDX_W-1:0]    rank_next;
   logic [SAMPLE_W:0]   mid_sum;

   assign rd_eff = rd_hit_ff ? rd_data_ff : '0;

   // Entry counts below the candidate if smaller, or equal at a lower index
   assign below = pend_ff && ((rd_eff < cand_ff) ||
                              ((rd_eff == cand_ff) && (pend_idx_ff < cand_idx_ff)));
   assign rank_next = rank_ff + IDX_W'(below);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};

   assign cmd_ready = (state_ff == ST_IDLE);
   assign mem_we    = cmd_valid && cmd_ready && (cmd_in.action == ACT_PUSH);
   assign rd_addr   = (state_ff == ST_SCAN) ? scan_idx_ff : cand_idx_ff;

   always_comb begin
      state_in      = state_ff;
      wr_pos_in     = wr_pos_ff;
      ring_valid_in = ring_valid_ff;
      cand_idx_in   = cand_idx_ff;
      scan_idx_in   = scan_idx_ff;
      pend_idx_in   = pend_idx_ff;
      pend_in       = pend_ff;
      rank_in       = rank_ff;
      cand_in       = cand_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      // Drop the result once taken
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_in.action == ACT_PUSH) begin
                  ring_valid_in[wr_pos_ff] = 1'b1;
                  wr_pos_in = (wr_pos_ff == LAST_IDX) ? '0 : wr_pos_ff + 1'b1;
               end else begin
                  cand_idx_in = '0;
                  state_in    = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_CAND;
         end
         ST_CAND: begin
            cand_in     = rd_eff;
            scan_idx_in = '0;
            rank_in     = '0;
            pend_in     = 1'b0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rank_in     = rank_next;
            pend_in     = 1'b1;
            pend_idx_in = scan_idx_ff;
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (rank_next == MID_LO) begin
               lo_in = cand_ff;
            end
            if (rank_next == MID_HI) begin
               hi_in = cand_ff;
            end
            pend_in = 1'b0;
            if (cand_idx_ff == LAST_IDX) begin
               state_in = ST_OUT;
            end else begin
               cand_idx_in = cand_idx_ff + 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mid_sum[SAMPLE_W:1];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_pos_ff     <= '0;
         ring_valid_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_pos_ff     <= wr_pos_in;
         ring_valid_ff <= ring_valid_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cand_idx_ff <= cand_idx_in;
      scan_idx_ff <= scan_idx_in;
      pend_idx_ff <= pend_idx_in;
      rank_ff     <= rank_in;
      cand_ff     <= cand_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Write on push, read one entry a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_pos_ff] <= cmd_in.sample;
      end
      rd_data_ff <= ring_mem[rd_addr];
      rd_hit_ff  <= ring_valid_ff[rd_addr];
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.median_value = rsp_data_ff;

endmodule : mwf_engine
`default_nettype wire

[rtl/median_window_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// A push passes through the holding register and the queue into the ring and gives no item.
// A report gives its item once the engine has ranked every entry, with one ring read per
// cycle, and the output register is free.
// Throughput: one push per cycle while the engine is idle; a report keeps the engine busy,
// while a holding register and a two-entry queue take up to three more items.
// Reset is synchronous; per-entry valid bits make the whole ring read as zero at once.
// ---------------------------------------------------------------------------
// Median window filter
// Sliding-window median over the last WINDOW converter samples.
// ---------------------------------------------------------------------------
module median_window_filter (
   input  wire logic clock,
   input  wire logic reset,
   mwf_req_if.sink   req_if,
   mwf_rsp_if.source rsp_if
);
   import mwf_pkg::*;

   cmd_type front_cmd, queue_cmd;
   logic    front_valid, front_ready;
   logic    queue_valid, queue_ready;

   mwf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_out   (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   mwf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_cmd   (front_cmd),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .rd_cmd   (queue_cmd),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready)
   );

   mwf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (queue_cmd),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .rsp_if    (rsp_if)
   );

endmodule : median_window_filter
`default_nettype wire

[test/mwf_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Median window filter checker
// Watches the request and response channels, keeps its own copy of the
// sample ring, works out the median for every accepted report item and
// compares each accepted response item with the oldest median outstanding.
// ---------------------------------------------------------------------------
module mwf_checker
   import mwf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mwf_req_if        req,
   mwf_rsp_if        rsp,
   output int        mismatch_count,
   output int        medians_pending
);

   localparam int REPORT_LIMIT = 10;

   logic [SAMPLE_W-1:0] ring_copy [WINDOW];
   int                  next_slot = 0;
   logic [SAMPLE_W-1:0] median_queue [$];
   int                  fails = 0;

   // Sort a copy of the ring and take the middle rank (mean of the two for
   // an even window, truncated)
   function automatic logic [SAMPLE_W-1:0] ring_median();
      logic [SAMPLE_W-1:0] sorted [WINDOW];
      logic [SAMPLE_W-1:0] key;
      logic [SAMPLE_W:0]   pair_sum;
      int                  j;
      foreach (sorted[i]) sorted[i] = ring_copy[i];
      for (int i = 1; i < WINDOW; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      if (WINDOW % 2 != 0) return sorted[(WINDOW - 1) / 2];
      pair_sum = {1'b0, sorted[WINDOW/2 - 1]} + {1'b0, sorted[WINDOW/2]};
      return pair_sum[SAMPLE_W:1];
   endfunction

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] expected_median;
      if (reset) begin
         foreach (ring_copy[i]) ring_copy[i] = '0;
         next_slot = 0;
         median_queue.delete();
      end else begin
         // Track pushes in the ring copy, queue a median for each report
         if (req.valid && req.ready) begin
            if (action_type'(req.action) == ACT_REPORT) begin
               median_queue.push_back(ring_median());
            end else begin
               ring_copy[next_slot] = req.sample;
               next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
            end
         end

         // Compare each response item with the oldest median outstanding
         if (rsp.valid && rsp.ready) begin
            if (median_queue.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT)
                  $display("unexpected median item %0d with none outstanding",
                           rsp.median_value);
            end else begin
               expected_median = median_queue.pop_front();
               if (rsp.median_value !== expected_median) begin
                  fails++;
                  if (fails <= REPORT_LIMIT)
                     $display("median mismatch: expected %0d, got %0d",
                              expected_median, rsp.median_value);
               end
            end
         end
      end
      mismatch_count  <= fails;
      medians_pending <= median_queue.size();
   end

endmodule : mwf_checker

[test/median_window_filter_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Median window filter testbench
// Feeds push and report items in random bursts, with directed extremes and
// half-full rings first, runs of pushes long enough to wrap the ring, and a
// response side that stalls on its own pattern including one long hold-off.
// The checker beside the block predicts every median and counts failures.
// ---------------------------------------------------------------------------
module median_window_filter_test;
   import mwf_pkg::*;

   localparam int QUIET_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 1200;
   localparam int HOLD_CYCLES  = 4000;
   localparam int HOLD_AFTER   = 120;
   localparam int ITEM_TARGET  = 580;

   typedef enum int {
      STYLE_ANY,
      STYLE_EXTREME,
      STYLE_CLUSTER,
      STYLE_CONSTANT
   } sample_style_type;

   typedef enum int {
      RX_OPEN,
      RX_RANDOM,
      RX_SPARSE
   } stall_pattern_type;

   logic clock = 1'b0;
   logic reset;
   int   burst_left   = 0;
   int   items_sent   = 0;
   int   quiet_cycles = 0;
   int   mismatch_count;
   int   medians_pending;

   mwf_req_if req_ch ();
   mwf_rsp_if rsp_ch ();

   median_window_filter uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   mwf_checker median_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .mismatch_count  (mismatch_count),
      .medians_pending (medians_pending)
   );

   always #5 clock = ~clock;

   // Offer one item, idling first for a random gap, possibly none, when the current burst is spent
   task automatic send_item(input action_type act, input logic [SAMPLE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            9:       gap = $urandom_range(30, 200);
            default: gap = $urandom_range(1, 12);
         endcase
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.sample <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_style_type style,
                                                       input logic [SAMPLE_W-1:0] centre);
      case (style)
         STYLE_EXTREME:  return $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : '0;
         STYLE_CLUSTER:  return centre ^ SAMPLE_W'($urandom_range(0, 7));
         STYLE_CONSTANT: return centre;
         default:        return SAMPLE_W'($urandom());
      endcase
   endfunction

   // Stimulus and verdict
   initial begin
      sample_style_type    style;
      logic [SAMPLE_W-1:0] centre;
      int                  run_len;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.action <= ACT_PUSH;
      req_ch.sample <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty ring, then a ring half full of maximum samples
      send_item(ACT_REPORT, '1);
      send_item(ACT_PUSH, '1);
      send_item(ACT_REPORT, '0);
      repeat (14) send_item(ACT_PUSH, '1);
      send_item(ACT_REPORT, '0);
      // Middle ranks split across different values
      send_item(ACT_PUSH, SAMPLE_W'(512));
      send_item(ACT_PUSH, SAMPLE_W'(1));
      send_item(ACT_REPORT, '1);
      send_item(ACT_PUSH, SAMPLE_W'(10'h155));
      send_item(ACT_PUSH, SAMPLE_W'(10'h2AA));
      send_item(ACT_REPORT, SAMPLE_W'(10'h2AA));

      // Runs of pushes with one value style, each closed by a report
      while (items_sent < ITEM_TARGET) begin
         style  = sample_style_type'($urandom_range(0, 3));
         centre = SAMPLE_W'($urandom());
         case ($urandom_range(0, 9))
            0, 1:    run_len = 0;
            7, 8:    run_len = $urandom_range(9, 20);
            9:       run_len = $urandom_range(WINDOW, WINDOW + 10);
            default: run_len = $urandom_range(1, 8);
         endcase
         repeat (run_len) send_item(ACT_PUSH, pick_sample(style, centre));
         send_item(ACT_REPORT, SAMPLE_W'($urandom()));
      end
      req_ch.valid <= 1'b0;

      // Drain outstanding medians, then watch for stray items
      do @(posedge clock); while (medians_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && medians_pending == 0) begin
         $display("median_window_filter_test OK");
      end else begin
         $display("median_window_filter_test NOT OK");
      end
      $finish;
   end

   // Response side: changing stall patterns, one long hold-off mid-run
   initial begin
      stall_pattern_type mode;
      int                mode_left;
      bit                held;
      mode_left = 0;
      held      = 1'b0;
      mode      = RX_OPEN;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && items_sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = stall_pattern_type'($urandom_range(0, 2));
               mode_left = $urandom_range(50, 600);
            end
            mode_left--;
            case (mode)
               RX_OPEN:   rsp_ch.ready <= 1'b1;
               RX_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default:   rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Watchdog: end the run after too long without any item moving
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("median_window_filter_test NOT OK");
            $finish;
         end
      end
   end

endmodule : median_window_filter_test
